>>> rtl/ed_pkg.sv
package ed_pkg;

    localparam int MAX_DIM   = 64;
    localparam int FRAC_BITS = 8;

    localparam int COMP_W = 16;
    localparam int SQ_W   = 2 * COMP_W;
    localparam int SUM_W  = 39;
    localparam int DIST_W = 27;
    localparam int OCNT_W = 7;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);

    // radicand is the sum scaled by 2^(2*FRAC_BITS)
    localparam int RAD_W  = SUM_W + 2 * FRAC_BITS;
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int ITER_W = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

    typedef enum logic [1:0] {
        R_IDLE,
        R_RUN,
        R_DONE
    } ed_state_t;

    typedef struct packed {
        logic accept;
        logic load_root;
        logic step_root;
        logic load_out;
    } ed_cmd_t;

    typedef struct packed {
        logic last_pending;
    } ed_status_t;

endpackage

>>> rtl/ed_ctrl.sv
module ed_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last,
    output logic              s_ready,
    input  logic              m_ready,
    output logic              m_valid,
    output ed_pkg::ed_cmd_t   cmd,
    input  ed_pkg::ed_status_t status
);
    import ed_pkg::*;

    ed_state_t         state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              m_valid_reg, m_valid_next;

    // a closing beat needs a free root engine when it reaches the sum stage
    assign s_ready = !s_last || (state_reg == R_IDLE && !status.last_pending);
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= R_IDLE;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        iter_next     = iter_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd           = '0;
        cmd.accept    = s_valid && s_ready;
        case (state_reg)
            R_IDLE: begin
                if (status.last_pending) begin
                    cmd.load_root = 1'b1;
                    iter_next     = ITER_W'(ROOT_W - 1);
                    state_next    = R_RUN;
                end
            end
            R_RUN: begin
                cmd.step_root = 1'b1;
                if (iter_reg == '0) begin
                    state_next = R_DONE;
                end else begin
                    iter_next = iter_reg - 1'b1;
                end
            end
            R_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = R_IDLE;
                end
            end
            default: begin
                state_next = R_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/ed_datapath.sv
module ed_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ed_pkg::ed_cmd_t             cmd,
    output ed_pkg::ed_status_t          status,
    input  logic signed [ed_pkg::COMP_W-1:0] p_component,
    input  logic signed [ed_pkg::COMP_W-1:0] q_component,
    input  logic                        last,
    output logic [ed_pkg::DIST_W-1:0]   distance,
    output logic [ed_pkg::OCNT_W-1:0]   component_count
);
    import ed_pkg::*;

    localparam int RAD2_W = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    logic signed [COMP_W:0] diff;
    logic [COMP_W-1:0]      mag;

    logic              sq_valid_reg;
    logic              sq_last_reg;
    logic [SQ_W-1:0]   sq_reg;

    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_sat;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_inc;

    logic [RAD2_W-1:0] rad_reg;
    logic [ROOT_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  root_cnt_reg;
    logic [REM_W-1:0]  rem_shift, trial, rem_diff;
    logic              take;

    logic [DIST_W-1:0] dist_reg;
    logic [OCNT_W-1:0] ocnt_reg;

    assign diff = {q_component[COMP_W-1], q_component}
                - {p_component[COMP_W-1], p_component};
    always_comb begin
        if (diff[COMP_W]) begin
            mag = COMP_W'(-diff);
        end else begin
            mag = diff[COMP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
            sq_last_reg  <= 1'b0;
        end else begin
            sq_valid_reg <= cmd.accept;
            sq_last_reg  <= cmd.accept && last;
        end
        if (cmd.accept) begin
            sq_reg <= mag * mag;
        end
    end

    assign status.last_pending = sq_valid_reg && sq_last_reg;

    // saturating accumulate
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign cnt_inc  = (cnt_reg < CNT_W'(MAX_DIM)) ? cnt_reg + 1'b1 : cnt_reg;

    always_comb begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (sq_valid_reg) begin
            sum_next = sq_last_reg ? '0 : sum_sat;
            cnt_next = sq_last_reg ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end else begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

    // digit-by-digit root, one result bit per step
    assign rem_shift = {rem_reg, rad_reg[RAD2_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign take      = rem_shift >= trial;
    assign rem_diff  = rem_shift - trial;

    always_ff @(posedge aclk) begin
        if (cmd.load_root) begin
            rad_reg      <= RAD2_W'({sum_sat, {(2 * FRAC_BITS){1'b0}}});
            rem_reg      <= '0;
            root_reg     <= '0;
            root_cnt_reg <= cnt_inc;
        end else if (cmd.step_root) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= take ? rem_diff[ROOT_W-1:0] : rem_shift[ROOT_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if ((root_reg >> DIST_W) != '0) begin
                dist_reg <= {DIST_W{1'b1}};
            end else begin
                dist_reg <= DIST_W'(root_reg);
            end
            ocnt_reg <= OCNT_W'(root_cnt_reg);
        end
    end

    assign distance        = dist_reg;
    assign component_count = ocnt_reg;

endmodule

>>> rtl/euclidean_distance_core.sv
// Channel  Direction  Payload                          Accepted when
// s_       in         p_component, q_component, last   s_valid && s_ready
// m_       out        distance, component_count        m_valid && m_ready
//
// One coordinate beat is taken per cycle while s_ready is high: the difference
// is squared in the input register stage and summed in the cycle after, so beats
// stream back to back. The closing beat hands the sum to a digit-by-digit root
// unit that settles one bit a cycle; a closing beat waits while that unit is busy
// or its result waits for the output register, ordinary beats keep flowing.
// m_valid rises when the finished root is loaded into the output register.
// Reset (aresetn low, synchronous) clears the sum, count, sequencer and m_valid.
// A stalled result holds in the output register without stopping accumulation.
module euclidean_distance_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [ed_pkg::COMP_W-1:0] s_p_component,
    input  logic signed [ed_pkg::COMP_W-1:0] s_q_component,
    input  logic                             s_last,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ed_pkg::DIST_W-1:0]        m_distance,
    output logic [ed_pkg::OCNT_W-1:0]        m_component_count
);
    import ed_pkg::*;

    ed_cmd_t    cmd;
    ed_status_t status;

    // sequence the root unit and the result handshake
    ed_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .cmd     (cmd),
        .status  (status)
    );

    // square, accumulate, root and hold the result
    ed_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .p_component     (s_p_component),
        .q_component     (s_q_component),
        .last            (s_last),
        .distance        (m_distance),
        .component_count (m_component_count)
    );

endmodule

>>> rtl/ed_checker.sv
module ed_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             s_last,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [ed_pkg::DIST_W-1:0]        m_distance,
    input logic [ed_pkg::OCNT_W-1:0]        m_component_count
);
    import ed_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance)
                               && $stable(m_component_count))
        else $error("result changed while stalled");

    // a result counts at least its closing beat and never more than the cap
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_component_count != '0
                 && m_component_count <= OCNT_W'(MAX_DIM))
        else $error("component count out of range");

    // drop any result on reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // ordinary beats are never stalled
    a_plain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_last |-> s_ready)
        else $error("non-closing beat stalled");

endmodule

bind euclidean_distance_core ed_checker u_ed_checker (.*);
